/* design/vec3_math_unit_assert.svh */
// ----------------------------------------------------------------------------
// vec3_math_unit assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef VEC3_MATH_UNIT_ASSERT_SVH
`define VEC3_MATH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define V3MU_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent implies consequent in the next cycle
`define V3MU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define V3MU_ASSERT_NOW(lbl, cond, msg)
`define V3MU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/v3mu_pkg.sv */
// ----------------------------------------------------------------------------
// v3mu_pkg
// Shared types and constants of the three-component vector unit.
// ----------------------------------------------------------------------------
package v3mu_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  // quotient bits of a normalized component (magnitude never exceeds one)
  localparam int QW = FRAC_BITS + 1;
  // square root steps over a 64-bit radicand, one result bit each
  localparam int SQ_STAGES = 32;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // command codes
  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_MUL    = 4'd2;
  localparam logic [3:0] CMD_SCALE  = 4'd3;
  localparam logic [3:0] CMD_CROSS  = 4'd4;
  localparam logic [3:0] CMD_DOT    = 4'd5;
  localparam logic [3:0] CMD_LEN_SQ = 4'd6;
  localparam logic [3:0] CMD_LEN    = 4'd7;
  localparam logic [3:0] CMD_NORM   = 4'd8;

  // decoded operation
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_CROSS,
    OP_DOT, OP_LEN_SQ, OP_LEN, OP_NORM, OP_NONE
  } op_e;

  typedef struct packed {
    logic        [3:0]  command;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               overflow;
  } out_item_t;

  // queue entry: classified item
  typedef struct packed {
    op_e                op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] s;
  } work_t;

endpackage

/* design/v3mu_front.sv */
// ----------------------------------------------------------------------------
// v3mu_front
// Accepts input transfers and decodes the command into an operation.
// ----------------------------------------------------------------------------
module v3mu_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  v3mu_pkg::in_item_t  in_data,
  output logic                push,
  output v3mu_pkg::work_t     push_data,
  input  logic                full
);

  // accept whenever the queue has room
  assign in_ready = !full;
  assign push     = in_valid && !full;

  // classify
  always_comb begin
    push_data     = '0;
    push_data.a_x = in_data.a_x;
    push_data.a_y = in_data.a_y;
    push_data.a_z = in_data.a_z;
    push_data.b_x = in_data.b_x;
    push_data.b_y = in_data.b_y;
    push_data.b_z = in_data.b_z;
    push_data.s   = in_data.scale_factor;
    case (in_data.command)
      v3mu_pkg::CMD_ADD:    push_data.op = v3mu_pkg::OP_ADD;
      v3mu_pkg::CMD_SUB:    push_data.op = v3mu_pkg::OP_SUB;
      v3mu_pkg::CMD_MUL:    push_data.op = v3mu_pkg::OP_MUL;
      v3mu_pkg::CMD_SCALE:  push_data.op = v3mu_pkg::OP_SCALE;
      v3mu_pkg::CMD_CROSS:  push_data.op = v3mu_pkg::OP_CROSS;
      v3mu_pkg::CMD_DOT:    push_data.op = v3mu_pkg::OP_DOT;
      v3mu_pkg::CMD_LEN_SQ: push_data.op = v3mu_pkg::OP_LEN_SQ;
      v3mu_pkg::CMD_LEN:    push_data.op = v3mu_pkg::OP_LEN;
      v3mu_pkg::CMD_NORM:   push_data.op = v3mu_pkg::OP_NORM;
      default:              push_data.op = v3mu_pkg::OP_NONE;
    endcase
  end

endmodule

/* design/v3mu_queue.sv */
// ----------------------------------------------------------------------------
// v3mu_queue
// Small FIFO that decouples the front from the execution pipeline.
// ----------------------------------------------------------------------------
`include "vec3_math_unit_assert.svh"

module v3mu_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  v3mu_pkg::work_t  push_data,
  output logic             full,
  input  logic             pop,
  output v3mu_pkg::work_t  pop_data,
  output logic             empty
);

  v3mu_pkg::work_t                mem [v3mu_pkg::QDEPTH];
  logic [v3mu_pkg::QAW-1:0]       wr_ptr;
  logic [v3mu_pkg::QAW-1:0]       rd_ptr;
  logic [v3mu_pkg::QAW:0]         count;

  assign full     = count == (v3mu_pkg::QAW+1)'(v3mu_pkg::QDEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  `V3MU_ASSERT_NOW(a_no_overrun, !(push && full), "push into full queue")
  `V3MU_ASSERT_NOW(a_no_underrun, !(pop && empty), "pop from empty queue")
  `V3MU_ASSERT_NOW(a_count_range, count <= (v3mu_pkg::QAW+1)'(v3mu_pkg::QDEPTH), "count too big")
  `V3MU_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1, "count not raised")

endmodule

/* design/v3mu_back.sv */
// ----------------------------------------------------------------------------
// v3mu_back
// Execution pipeline: products, sums, saturation, square root, division.
// ----------------------------------------------------------------------------
module v3mu_back (
  input  logic                clk,
  input  logic                rst,
  output logic                pop,
  input  v3mu_pkg::work_t     pop_data,
  input  logic                empty,
  output logic                out_valid,
  input  logic                out_ready,
  output v3mu_pkg::out_item_t out_data
);

  localparam int F  = v3mu_pkg::FRAC_BITS;
  localparam int QW = v3mu_pkg::QW;
  localparam int NS = v3mu_pkg::SQ_STAGES;

  localparam logic signed [65:0] MAXV = 66'sd2147483647;
  localparam logic signed [65:0] MINV = -66'sd2147483648;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } sat_t;

  // state carried along the root and divide stages
  typedef struct packed {
    v3mu_pkg::op_e    op;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             ovf;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } carry_t;

  function automatic sat_t sat_wide(input logic signed [65:0] v);
    sat_t o;
    o.ovf = 1'b0;
    if (v > MAXV) begin
      o.val = 32'sh7fffffff;
      o.ovf = 1'b1;
    end else if (v < MINV) begin
      o.val = 32'sh80000000;
      o.ovf = 1'b1;
    end else begin
      o.val = v[31:0];
    end
    return o;
  endfunction

  // whole pipeline moves when the output register can take a result
  logic adv;
  assign adv = !out_valid || out_ready;
  assign pop = adv && !empty;

  // ---- E0: operands from the queue
  logic               e0_vld;
  v3mu_pkg::op_e      e0_op;
  logic signed [31:0] e0_a [3];
  logic signed [31:0] e0_b [3];
  logic signed [31:0] e0_s;

  always_ff @(posedge clk) begin
    if (rst) e0_vld <= 1'b0;
    else if (adv) e0_vld <= !empty;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_op   <= pop_data.op;
      e0_a[0] <= pop_data.a_x;
      e0_a[1] <= pop_data.a_y;
      e0_a[2] <= pop_data.a_z;
      e0_b[0] <= pop_data.b_x;
      e0_b[1] <= pop_data.b_y;
      e0_b[2] <= pop_data.b_z;
      e0_s    <= pop_data.s;
    end
  end

  // ---- E1: multiplier operand select and products
  logic signed [31:0] mx [3], my [3], nx [3], ny [3];

  always_comb begin
    int j, k;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      mx[i] = e0_a[i];
      my[i] = e0_b[i];
      nx[i] = '0;
      ny[i] = '0;
      case (e0_op)
        v3mu_pkg::OP_SCALE: my[i] = e0_s;
        v3mu_pkg::OP_CROSS: begin
          mx[i] = e0_a[j];
          my[i] = e0_b[k];
          nx[i] = e0_a[k];
          ny[i] = e0_b[j];
        end
        v3mu_pkg::OP_LEN_SQ, v3mu_pkg::OP_LEN, v3mu_pkg::OP_NORM: my[i] = e0_a[i];
        default: ;
      endcase
    end
  end

  logic               e1_vld;
  v3mu_pkg::op_e      e1_op;
  logic signed [31:0] e1_a [3], e1_b [3];
  logic signed [63:0] e1_m [3], e1_n [3];

  always_ff @(posedge clk) begin
    if (rst) e1_vld <= 1'b0;
    else if (adv) e1_vld <= e0_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_op <= e0_op;
      for (int i = 0; i < 3; i++) begin
        e1_a[i] <= e0_a[i];
        e1_b[i] <= e0_b[i];
        e1_m[i] <= mx[i] * my[i];
        e1_n[i] <= nx[i] * ny[i];
      end
    end
  end

  // ---- E2: exact sums
  logic               e2_vld;
  v3mu_pkg::op_e      e2_op;
  logic signed [31:0] e2_a [3];
  logic signed [32:0] e2_as [3];
  logic signed [64:0] e2_v [3];
  logic signed [65:0] e2_dot;

  always_ff @(posedge clk) begin
    if (rst) e2_vld <= 1'b0;
    else if (adv) e2_vld <= e1_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_op  <= e1_op;
      e2_dot <= 66'(e1_m[0]) + 66'(e1_m[1]) + 66'(e1_m[2]);
      for (int i = 0; i < 3; i++) begin
        e2_a[i]  <= e1_a[i];
        e2_v[i]  <= 65'(e1_m[i]) - 65'(e1_n[i]);
        e2_as[i] <= (e1_op == v3mu_pkg::OP_SUB) ? 33'(e1_a[i]) - 33'(e1_b[i])
                                                 : 33'(e1_a[i]) + 33'(e1_b[i]);
      end
    end
  end

  // ---- E3: floor shift and saturation, root radicand
  carry_t c3;

  always_comb begin
    sat_t sv, ss;
    logic ovf_v;
    ovf_v = 1'b0;
    c3    = '0;
    c3.op = e2_op;
    for (int i = 0; i < 3; i++) begin
      if (e2_op inside {v3mu_pkg::OP_ADD, v3mu_pkg::OP_SUB}) sv = sat_wide(66'(e2_as[i]));
      else sv = sat_wide(66'(e2_v[i] >>> F));
      c3.r[i]   = sv.val;
      ovf_v     = ovf_v | sv.ovf;
      c3.neg[i] = e2_a[i][31];
      c3.mag[i] = e2_a[i][31] ? (~e2_a[i] + 32'd1) : e2_a[i];
    end
    ss     = sat_wide(e2_dot >>> F);
    c3.sc  = ss.val;
    c3.ovf = (e2_op inside {v3mu_pkg::OP_DOT, v3mu_pkg::OP_LEN_SQ}) ? ss.ovf : ovf_v;
  end

  logic        e3_vld;
  carry_t      e3_c;
  logic [63:0] e3_sq;

  always_ff @(posedge clk) begin
    if (rst) e3_vld <= 1'b0;
    else if (adv) e3_vld <= e2_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_c  <= c3;
      e3_sq <= e2_dot[63:0];
    end
  end

  // ---- square root: one result bit per stage
  logic        sq_vld [NS];
  carry_t      sq_c   [NS];
  logic [63:0] sq_s   [NS];
  logic [63:0] sq_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic        vi;
    carry_t      ci;
    logic [63:0] si, ri, trial;
    logic        take;

    if (k == 0) begin : g_first
      assign vi = e3_vld;
      assign ci = e3_c;
      assign si = e3_sq;
      assign ri = '0;
    end else begin : g_next
      assign vi = sq_vld[k-1];
      assign ci = sq_c[k-1];
      assign si = sq_s[k-1];
      assign ri = sq_r[k-1];
    end

    assign trial = ri + BIT;
    assign take  = si >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k] <= 1'b0;
      else if (adv) sq_vld[k] <= vi;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k] <= ci;
        sq_s[k] <= take ? si - trial : si;
        sq_r[k] <= take ? (ri >> 1) + BIT : ri >> 1;
      end
    end
  end

  // ---- divide |a| * 2^F by the length: one quotient bit per stage
  logic          dv_vld [QW];
  carry_t        dv_c   [QW];
  logic [31:0]   dv_l   [QW];
  logic [32:0]   dv_rem [QW][3];
  logic [QW-1:0] dv_q   [QW][3];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic          vi;
    carry_t        ci;
    logic [31:0]   li;
    logic [32:0]   ri [3];
    logic [QW-1:0] qi [3];
    logic [32:0]   rs [3];
    logic          tk [3];

    if (k == 0) begin : g_first
      assign vi = sq_vld[NS-1];
      assign ci = sq_c[NS-1];
      assign li = sq_r[NS-1][31:0];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign ri[i] = {1'b0, sq_c[NS-1].mag[i]};
        assign qi[i] = '0;
      end
    end else begin : g_next
      assign vi = dv_vld[k-1];
      assign ci = dv_c[k-1];
      assign li = dv_l[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign ri[i] = dv_rem[k-1][i];
        assign qi[i] = dv_q[k-1][i];
      end
    end

    // the first step compares |a| itself; later steps shift the remainder
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rs[i] = (k == 0) ? ri[i] : {ri[i][31:0], 1'b0};
        tk[i] = rs[i] >= {1'b0, li};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k] <= 1'b0;
      else if (adv) dv_vld[k] <= vi;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[k] <= ci;
        dv_l[k] <= li;
        for (int i = 0; i < 3; i++) begin
          dv_rem[k][i] <= tk[i] ? rs[i] - {1'b0, li} : rs[i];
          dv_q[k][i]   <= {qi[i][QW-2:0], tk[i]};
        end
      end
    end
  end

  // ---- final select per operation
  v3mu_pkg::out_item_t fin;
  carry_t              cl;
  logic [31:0]         fl;

  assign cl = dv_c[QW-1];
  assign fl = dv_l[QW-1];

  always_comb begin
    logic [31:0] nq [3];
    logic [31:0] qx;
    fin = '0;
    for (int i = 0; i < 3; i++) begin
      qx    = {{(32-QW){1'b0}}, dv_q[QW-1][i]};
      nq[i] = cl.neg[i] ? (~qx + 32'd1) : qx;
    end
    case (cl.op)
      v3mu_pkg::OP_ADD, v3mu_pkg::OP_SUB, v3mu_pkg::OP_MUL,
      v3mu_pkg::OP_SCALE, v3mu_pkg::OP_CROSS: begin
        fin.r_x      = cl.r[0];
        fin.r_y      = cl.r[1];
        fin.r_z      = cl.r[2];
        fin.overflow = cl.ovf;
      end
      v3mu_pkg::OP_DOT, v3mu_pkg::OP_LEN_SQ: begin
        fin.scalar_out = cl.sc;
        fin.overflow   = cl.ovf;
      end
      v3mu_pkg::OP_LEN: begin
        if (fl[31]) begin
          fin.scalar_out = 32'sh7fffffff;
          fin.overflow   = 1'b1;
        end else begin
          fin.scalar_out = fl;
        end
      end
      v3mu_pkg::OP_NORM: begin
        // zero length means a is zero, so the unchanged input is all zeros
        if (fl != '0) begin
          fin.r_x = nq[0];
          fin.r_y = nq[1];
          fin.r_z = nq[2];
        end
      end
      default: ;
    endcase
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_vld[QW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= fin;
  end

endmodule

/* design/vec3_math_unit.sv */
// ----------------------------------------------------------------------------
// vec3_math_unit
// Three-component Q16.16 vector ALU with a decoupled front and back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries a command, vectors a and
//   b and a scale factor. Output channel out_valid/out_ready/out_data carries
//   one result per input: r_x..r_z for vector commands, scalar_out for dot,
//   squared length and length, and an overflow flag for any saturation.
//   Throughput is one transfer per cycle on each side while out_ready is
//   held high. Every command, normalize or not, flows through the queue,
//   E0 to E3, the 32-step square root pipeline, the FRAC_BITS + 1 step
//   divider for the Q16.16 quotient of normalize, and the output register.
//   A four-entry queue sits between the decoder and the pipeline. When the
//   receiver stalls, the pipeline holds in place, the queue fills, and
//   in_ready drops once it is full. Synchronous reset empties the queue and
//   clears all stage valids; no result is pending after reset.
// ----------------------------------------------------------------------------
module vec3_math_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  v3mu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output v3mu_pkg::out_item_t out_data
);

  logic            push, full, pop, empty;
  v3mu_pkg::work_t push_data, pop_data;

  // decode
  v3mu_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decoupling queue
  v3mu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // execution pipeline
  v3mu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed vector commands through vec3_math_unit, predicts
// every result in the bench and compares each output transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY = v3mu_pkg::FRAC_BITS + 38;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  v3mu_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  v3mu_pkg::out_item_t out_data;

  v3mu_pkg::out_item_t expected_q[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        recv_hold = 1'b0;

  vec3_math_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // expected result of one command
  function automatic v3mu_pkg::out_item_t vec_result(input v3mu_pkg::in_item_t it);
    v3mu_pkg::out_item_t r;
    logic ovf;
    logic signed [127:0] a[3], b[3], s, acc, num;
    logic [63:0] sq, len;
    int j, k;
    r = '0;
    ovf = 1'b0;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
    s = it.scale_factor;
    sq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    len = int_sqrt(sq);
    case (it.command)
      v3mu_pkg::CMD_ADD, v3mu_pkg::CMD_SUB, v3mu_pkg::CMD_MUL, v3mu_pkg::CMD_SCALE,
      v3mu_pkg::CMD_CROSS, v3mu_pkg::CMD_NORM: begin
        logic signed [31:0] c[3];
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          case (it.command)
            v3mu_pkg::CMD_ADD:   acc = a[i] + b[i];
            v3mu_pkg::CMD_SUB:   acc = a[i] - b[i];
            v3mu_pkg::CMD_MUL:   acc = (a[i] * b[i]) >>> v3mu_pkg::FRAC_BITS;
            v3mu_pkg::CMD_SCALE: acc = (a[i] * s) >>> v3mu_pkg::FRAC_BITS;
            v3mu_pkg::CMD_CROSS:
              acc = (a[j] * b[k] - a[k] * b[j]) >>> v3mu_pkg::FRAC_BITS;
            default: begin
              // zero-length normalize passes a through
              if (len == 0) acc = a[i];
              else begin
                num = a[i] <<< v3mu_pkg::FRAC_BITS;
                acc = num / $signed({64'd0, len});
              end
            end
          endcase
          c[i] = clamp32(acc, ovf);
        end
        r.r_x = c[0]; r.r_y = c[1]; r.r_z = c[2];
      end
      v3mu_pkg::CMD_DOT:
        r.scalar_out = clamp32((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> v3mu_pkg::FRAC_BITS,
                               ovf);
      v3mu_pkg::CMD_LEN_SQ:
        r.scalar_out = clamp32((a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) >>> v3mu_pkg::FRAC_BITS,
                               ovf);
      v3mu_pkg::CMD_LEN:
        r.scalar_out = clamp32($signed({64'd0, len}), ovf);
      default: ;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  // one input transfer, with optional random idle beforehand; valid stays
  // high afterwards so the next item can follow back to back
  task automatic send_vec(input v3mu_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(vec_result(it));
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic v3mu_pkg::in_item_t rand_item();
    v3mu_pkg::in_item_t it;
    it.command = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                           : 4'($urandom_range(8));
    it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp();
    it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp();
    it.scale_factor = rand_comp();
    return it;
  endfunction

  // receiver: random stalls, plus an optional long hold
  always @(negedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        v3mu_pkg::out_item_t e;
        e = expected_q.pop_front();
        if (e.r_x !== out_data.r_x)
          $display("%0t: r_x exp %h got %h", $time, e.r_x, out_data.r_x);
        if (e.r_y !== out_data.r_y)
          $display("%0t: r_y exp %h got %h", $time, e.r_y, out_data.r_y);
        if (e.r_z !== out_data.r_z)
          $display("%0t: r_z exp %h got %h", $time, e.r_z, out_data.r_z);
        if (e.scalar_out !== out_data.scalar_out)
          $display("%0t: scalar_out exp %h got %h", $time, e.scalar_out,
                   out_data.scalar_out);
        if (e.overflow !== out_data.overflow)
          $display("%0t: overflow exp %b got %b", $time, e.overflow,
                   out_data.overflow);
        if (e !== out_data) fail_count++;
      end
    end
  end

  // stop sending and wait for every outstanding result
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // every command at field extremes and the special cases
  task automatic test_directed();
    v3mu_pkg::in_item_t it;
    for (int c = 0; c < 16; c++) begin
      it = '{command: 4'(c), a_x: 32'sh7fffffff, a_y: 32'sh80000000,
             a_z: 32'sh00010000, b_x: 32'sh80000000, b_y: 32'sh7fffffff,
             b_z: 32'shffff0000, scale_factor: 32'sh80000000};
      send_vec(it);
    end
    // zero-length normalize and zero length
    it = '0;
    it.command = v3mu_pkg::CMD_NORM; it.b_x = 32'sh12345678;
    send_vec(it);
    it.command = v3mu_pkg::CMD_LEN;
    send_vec(it);
    // small exact values
    it = '{command: v3mu_pkg::CMD_NORM, a_x: 32'sh00030000, a_y: 32'sh00040000,
           a_z: 0, b_x: 0, b_y: 0, b_z: 0, scale_factor: 32'sh00020000};
    send_vec(it);
    it.command = v3mu_pkg::CMD_SCALE;
    send_vec(it);
    it.command = v3mu_pkg::CMD_CROSS; it.b_z = 32'sh00010000;
    send_vec(it);
    it.command = v3mu_pkg::CMD_DOT; it.a_x = -1; it.b_x = 1;
    send_vec(it);
    wait_drain();
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) send_vec(rand_item());
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (150) @(negedge clk);
        recv_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 80; i++) send_vec(rand_item());
    wait_drain();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(100, 0, 0);
    test_random(100, 65, 0);
    wait_drain();
    test_random(100, 0, 65);
    test_random(100, 12, 12);
    test_random(100, 0, 0);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drain();
    repeat (LATENCY + 20) @(negedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/v3mu_pkg.sv
design/v3mu_front.sv
design/v3mu_queue.sv
design/v3mu_back.sv
design/vec3_math_unit.sv
verif/tb_top.sv
